// ===== rtl/cgte_pkg.sv =====
// Shared types, sizes and codes for the coset graph table engine.
`default_nettype none

package cgte_pkg;

   // Table geometry
   localparam int MAX_RANK   = 4;
   localparam int DEGREE_CAP = 16;
   localparam int TABLE_SIZE = MAX_RANK * DEGREE_CAP;
   localparam int TIDX_W     = $clog2(TABLE_SIZE);

   // Field widths
   localparam int VERT_W   = 5;
   localparam int LETTER_W = 4;
   localparam int RANK_W   = 3;
   localparam int EDGE_W   = 7;
   localparam int PROD_W   = VERT_W + RANK_W;

   // Request codes
   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_ACT  = 2'd1;
   localparam logic [1:0] REQ_SCAN = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OCCUPIED = 2'd1;
   localparam logic [1:0] ST_BAD      = 2'd2;

   // Source of a result beat
   localparam logic [1:0] RK_EXEC = 2'd0;
   localparam logic [1:0] RK_ACT  = 2'd1;
   localparam logic [1:0] RK_SCAN = 2'd2;

   localparam logic [RANK_W-1:0] RANK_RESET = 3'd2;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic signed [LETTER_W-1:0] letter;
      logic [VERT_W-1:0]          src_vert;
      logic [VERT_W-1:0]          dst_vert;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [VERT_W-1:0]          target_vertex;
      logic signed [LETTER_W-1:0] slot_letter;
      logic [VERT_W-1:0]          slot_vertex;
      logic [VERT_W-1:0]          degree_now;
      logic [EDGE_W-1:0]          edge_count;
   } rsp_beat_type;

   typedef struct packed {
      logic       capture;
      logic       exec;
      logic       scan_start;
      logic       scan_next;
      logic       load_rsp;
      logic [1:0] rsp_kind;
   } cgte_cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       act_bad;
      logic       scan_full;
      logic       scan_end;
      logic       scan_hit;
   } cgte_stat_type;

endpackage

`default_nettype wire

// ===== rtl/cgte_ctrl.sv =====
// Sequencing state machine for the coset graph table engine.
`default_nettype none

module cgte_ctrl
   import cgte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire cgte_stat_type stat,
   output cgte_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // Take a beat only when idle and the result register is free by this edge
   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.req_kind)
               REQ_ADD: begin
                  cmd.exec     = 1'b1;
                  cmd.load_rsp = 1'b1;
                  cmd.rsp_kind = RK_EXEC;
                  state_in     = S_IDLE;
               end
               REQ_ACT: begin
                  if (stat.act_bad) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_kind = RK_EXEC;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               REQ_SCAN: begin
                  if (stat.scan_full) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_kind = RK_EXEC;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  cmd.load_rsp = 1'b1;
                  cmd.rsp_kind = RK_EXEC;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            cmd.load_rsp = 1'b1;
            cmd.rsp_kind = RK_ACT;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            if (stat.scan_end || stat.scan_hit) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_kind = RK_SCAN;
               state_in     = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result beat until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cgte_dp.sv =====
// Tables, counters, scan cursor and result register of the coset graph table engine.
`default_nettype none

module cgte_dp
   import cgte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire req_beat_type      req_data,
   input  wire logic              csr_we,
   input  wire logic [RANK_W-1:0] csr_data,
   input  wire cgte_cmd_type      cmd,
   output cgte_stat_type          stat,
   output rsp_beat_type           rsp_data
);

   localparam logic [VERT_W-1:0] DEG_MAX   = VERT_W'(DEGREE_CAP);
   localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(MAX_RANK);
   localparam logic [PROD_W-1:0] TAB_LIMIT = PROD_W'(TABLE_SIZE);
   localparam logic [EDGE_W-1:0] EDGE_SAT  = {EDGE_W{1'b1}};

   // Request and state registers
   req_beat_type      req_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [VERT_W-1:0] vc_ff, vc_in;
   logic [EDGE_W-1:0] edges_ff, edges_in;
   logic [TIDX_W-1:0] cursor_ff;

   // Tables: data in memories, occupancy in flip-flops
   logic [VERT_W-1:0]     out_mem [TABLE_SIZE];
   logic [VERT_W-1:0]     in_mem  [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] out_vld_ff;
   logic [TABLE_SIZE-1:0] in_vld_ff;
   logic [VERT_W-1:0]     out_rd_ff, in_rd_ff;
   logic                  act_vld_ff;

   // Scan walker
   logic [TIDX_W:0]   n_ff;
   logic [RANK_W-1:0] l_ff;
   logic [VERT_W-1:0] v_ff;

   rsp_beat_type rsp_ff, rsp_in;

   // Decode
   logic [RANK_W-1:0]   r_eff;
   logic [LETTER_W-1:0] lt, mag;
   logic                neg, mag_ok;
   logic [VERT_W-1:0]   src, dst, vc_next1;
   logic                add_pre_bad, add_ovf, add_occ, add_write, add_grow, is_add;
   logic [PROD_W-1:0]   oi, ii, ai;
   logic [TIDX_W-1:0]   oi_idx, ii_idx, ai_idx;
   logic                act_bad;
   logic [PROD_W-1:0]   prod, limit;
   logic [TIDX_W-1:0]   n_idx;
   logic                past, hit_out, hit_in, scan_end, scan_hit;
   logic [LETTER_W-1:0] lp1;

   always_comb begin
      if (rank_ff == '0) begin
         r_eff = RANK_W'(1);
      end else if (rank_ff > RANK_MAX) begin
         r_eff = RANK_MAX;
      end else begin
         r_eff = rank_ff;
      end
   end

   assign lt       = req_ff.letter;
   assign neg      = lt[LETTER_W-1];
   assign mag      = neg ? (~lt + LETTER_W'(1)) : lt;
   assign mag_ok   = (mag != '0) && (mag <= LETTER_W'(r_eff));
   assign vc_next1 = vc_ff + VERT_W'(1);
   assign is_add   = (req_ff.req_type == REQ_ADD);

   // Add edge: swap endpoints on an inverse letter
   assign src = neg ? req_ff.dst_vert : req_ff.src_vert;
   assign dst = neg ? req_ff.src_vert : req_ff.dst_vert;
   assign add_pre_bad = !mag_ok || (src == '0) || (dst == '0) ||
                        (src > vc_next1) || (dst > vc_next1) ||
                        (src > DEG_MAX) || (dst > DEG_MAX);
   assign oi = PROD_W'(src - VERT_W'(1)) * PROD_W'(r_eff) + PROD_W'(mag - LETTER_W'(1));
   assign ii = PROD_W'(dst - VERT_W'(1)) * PROD_W'(r_eff) + PROD_W'(mag - LETTER_W'(1));
   assign oi_idx    = oi[TIDX_W-1:0];
   assign ii_idx    = ii[TIDX_W-1:0];
   assign add_ovf   = (oi >= TAB_LIMIT) || (ii >= TAB_LIMIT);
   assign add_occ   = out_vld_ff[oi_idx] || in_vld_ff[ii_idx];
   assign add_grow  = cmd.exec && is_add && !add_pre_bad &&
                      ((src > vc_ff) || (dst > vc_ff)) && (vc_ff < DEG_MAX);
   assign add_write = cmd.exec && is_add && !add_pre_bad && !add_ovf && !add_occ;

   // Act by: vertex must already exist
   assign ai = PROD_W'(req_ff.src_vert - VERT_W'(1)) * PROD_W'(r_eff) +
               PROD_W'(mag - LETTER_W'(1));
   assign ai_idx  = ai[TIDX_W-1:0];
   assign act_bad = !mag_ok || (req_ff.src_vert == '0) ||
                    (req_ff.src_vert > vc_ff) || (req_ff.src_vert > DEG_MAX) ||
                    (ai >= TAB_LIMIT);

   // Scan: walk slots from zero, test only from the cursor on
   assign prod     = PROD_W'(r_eff) * PROD_W'(vc_ff);
   assign limit    = (prod > TAB_LIMIT) ? TAB_LIMIT : prod;
   assign n_idx    = n_ff[TIDX_W-1:0];
   assign scan_end = PROD_W'(n_ff) >= limit;
   assign past     = n_ff >= (TIDX_W + 1)'(cursor_ff);
   assign hit_out  = past && !out_vld_ff[n_idx];
   assign hit_in   = past && !in_vld_ff[n_idx];
   assign scan_hit = !scan_end && (hit_out || hit_in);
   assign lp1      = LETTER_W'(l_ff) + LETTER_W'(1);

   assign stat.req_kind  = req_ff.req_type;
   assign stat.act_bad   = act_bad;
   assign stat.scan_full = (prod == PROD_W'(edges_ff));
   assign stat.scan_end  = scan_end;
   assign stat.scan_hit  = scan_hit;

   // Degree and edge count after this cycle
   always_comb begin
      vc_in    = vc_ff;
      edges_in = edges_ff;
      if (add_grow) begin
         vc_in = vc_next1;
      end
      if (add_write && (edges_ff != EDGE_SAT)) begin
         edges_in = edges_ff + EDGE_W'(1);
      end
   end

   // Build the result beat
   always_comb begin
      rsp_in            = '0;
      rsp_in.status     = ST_OK;
      rsp_in.degree_now = vc_in;
      rsp_in.edge_count = edges_in;
      case (cmd.rsp_kind)
         RK_EXEC: begin
            case (req_ff.req_type)
               REQ_ADD: begin
                  if (add_pre_bad || add_ovf) begin
                     rsp_in.status = ST_BAD;
                  end else if (add_occ) begin
                     rsp_in.status = ST_OCCUPIED;
                  end
               end
               REQ_ACT:  rsp_in.status = ST_BAD;
               REQ_SCAN: rsp_in.status = ST_OK;
               default:  rsp_in.status = ST_BAD;
            endcase
         end
         RK_ACT: begin
            if (act_vld_ff) begin
               rsp_in.target_vertex = neg ? in_rd_ff : out_rd_ff;
            end
         end
         RK_SCAN: begin
            if (scan_hit) begin
               rsp_in.slot_letter = hit_out ? lp1 : (~lp1 + LETTER_W'(1));
               rsp_in.slot_vertex = v_ff;
            end
         end
         default: begin
            rsp_in.status = ST_BAD;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff    <= RANK_RESET;
         vc_ff      <= VERT_W'(1);
         edges_ff   <= '0;
         cursor_ff  <= '0;
         out_vld_ff <= '0;
         in_vld_ff  <= '0;
      end else begin
         if (csr_we) begin
            rank_ff <= csr_data;
         end
         vc_ff    <= vc_in;
         edges_ff <= edges_in;
         if (add_write) begin
            out_vld_ff[oi_idx] <= 1'b1;
            in_vld_ff[ii_idx]  <= 1'b1;
         end
         if (cmd.load_rsp && (cmd.rsp_kind == RK_SCAN) && scan_hit) begin
            cursor_ff <= n_idx;
         end
      end
   end

   // Table memories with registered reads
   always_ff @(posedge clock) begin
      if (add_write) begin
         out_mem[oi_idx] <= dst;
         in_mem[ii_idx]  <= src;
      end
      out_rd_ff  <= out_mem[ai_idx];
      in_rd_ff   <= in_mem[ai_idx];
      act_vld_ff <= neg ? in_vld_ff[ai_idx] : out_vld_ff[ai_idx];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
      if (cmd.scan_start) begin
         n_ff <= '0;
         l_ff <= '0;
         v_ff <= VERT_W'(1);
      end else if (cmd.scan_next) begin
         n_ff <= n_ff + (TIDX_W + 1)'(1);
         if (l_ff == (r_eff - RANK_W'(1))) begin
            l_ff <= '0;
            v_ff <= v_ff + VERT_W'(1);
         end else begin
            l_ff <= l_ff + RANK_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/coset_graph_table_engine_top.sv =====
// Top level of the coset graph table engine.
//
//   channel   direction  handshake        payload
//   req_      in         valid / stall    req_beat_type
//   rsp_      out        valid / stall    rsp_beat_type
//   csr_      in         valid / ready    rank, 3 bits
//
// Add edge and rejected requests: the result beat is loaded from the execute state.
// Act by: the result beat waits for the registered read of the table memory.
// Empty slot scan: one slot per cycle through the occupancy flags, up to rank * degree slots
// (64 at rank 4, degree 16); a complete graph answers from the execute state without a scan.
// Synchronous reset clears occupancy flags at once, so no clearing pass is needed.
// A waiting result does not block the next request beat while it is taken that edge.
`default_nettype none

module coset_graph_table_engine_top
   import cgte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_beat_type      req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_beat_type           rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [RANK_W-1:0] csr_data
);

   cgte_cmd_type  cmd;
   cgte_stat_type stat;

   assign csr_ready = 1'b1;

   cgte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cgte_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/cgte_checker.sv =====
// Port-level checks for the coset graph table engine, bound to its top level.
`default_nettype none

module cgte_checker
   import cgte_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_beat_type rsp_data
);

   logic              owed_ff;
   logic [EDGE_W-1:0] last_edges_ff;
   logic [VERT_W-1:0] last_deg_ff;
   logic              req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Track the one request whose result is not yet taken
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff       <= 1'b0;
         last_edges_ff <= '0;
         last_deg_ff   <= VERT_W'(1);
      end else begin
         if (req_take) begin
            owed_ff <= 1'b1;
         end else if (rsp_take) begin
            owed_ff <= 1'b0;
         end
         if (rsp_take) begin
            last_edges_ff <= rsp_data.edge_count;
            last_deg_ff   <= rsp_data.degree_now;
         end
      end
   end

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff)
      else $error("result beat without an owed request");

   a_one_owed: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!owed_ff || rsp_take))
      else $error("request taken while a result is still owed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

   a_monotone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.edge_count >= last_edges_ff) &&
                     (rsp_data.degree_now >= last_deg_ff)))
      else $error("edge count or degree went backward");

endmodule

bind coset_graph_table_engine_top cgte_checker u_checker (.*);

`default_nettype wire

// ===== test/cgte_result_checker.sv =====
// Result checker for the coset graph table engine: predicts each response beat and scores it.
`timescale 1ns / 1ps

module cgte_result_checker
   import cgte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire req_beat_type      req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rsp_beat_type      rsp_data,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [RANK_W-1:0] csr_data,
   output int                     error_count,
   output int                     results_owed,
   output int                     graph_degree
);

   // Mirror of the graph held by the block
   logic [RANK_W-1:0] rank_reg;
   logic [VERT_W-1:0] out_links [TABLE_SIZE];
   logic [VERT_W-1:0] in_links  [TABLE_SIZE];
   int unsigned       vert_total;
   int unsigned       edge_total;
   int unsigned       cursor_pos;
   rsp_beat_type      owed_q [$];
   int                mismatch_total = 0;

   // Apply one request beat to the mirror and return the response it should produce
   function automatic rsp_beat_type apply_request(input req_beat_type rq);
      rsp_beat_type res;
      int unsigned  r, mag, src, dst, oi, ii, lim, n;
      logic         neg;
      logic         hit;
      res = '0;
      hit = 1'b0;
      r = (rank_reg == 0) ? 1 : (rank_reg > MAX_RANK) ? MAX_RANK : rank_reg;
      neg = rq.letter[LETTER_W-1];
      mag = neg ? (1 << LETTER_W) - rq.letter[LETTER_W-1:0] : rq.letter[LETTER_W-1:0];
      case (rq.req_type)
         REQ_ADD: begin
            // negative letter runs the edge backwards
            src = neg ? rq.dst_vert : rq.src_vert;
            dst = neg ? rq.src_vert : rq.dst_vert;
            if (mag == 0 || mag > r || src == 0 || dst == 0 ||
                src > vert_total + 1 || dst > vert_total + 1 ||
                src > DEGREE_CAP || dst > DEGREE_CAP) begin
               res.status = ST_BAD;
            end else begin
               // degree grows even when the slot turns out to be taken
               if ((src > vert_total || dst > vert_total) && vert_total < DEGREE_CAP)
                  vert_total++;
               oi = (src - 1) * r + mag - 1;
               ii = (dst - 1) * r + mag - 1;
               if (oi >= TABLE_SIZE || ii >= TABLE_SIZE) begin
                  res.status = ST_BAD;
               end else if (out_links[oi] != 0 || in_links[ii] != 0) begin
                  res.status = ST_OCCUPIED;
               end else begin
                  out_links[oi] = VERT_W'(dst);
                  in_links[ii]  = VERT_W'(src);
                  if (edge_total < 127) edge_total++;
               end
            end
         end
         REQ_ACT: begin
            if (mag == 0 || mag > r || rq.src_vert == 0 ||
                rq.src_vert > vert_total || rq.src_vert > DEGREE_CAP) begin
               res.status = ST_BAD;
            end else begin
               oi = (rq.src_vert - 1) * r + mag - 1;
               if (oi >= TABLE_SIZE) res.status = ST_BAD;
               else res.target_vertex = neg ? in_links[oi] : out_links[oi];
            end
         end
         REQ_SCAN: begin
            // resume from the cursor, outgoing before incoming in each slot
            lim = r * vert_total;
            if (lim > TABLE_SIZE) lim = TABLE_SIZE;
            if (r * vert_total != edge_total) begin
               for (n = cursor_pos; n < lim && !hit; n++) begin
                  if (out_links[n] == 0) begin
                     hit = 1'b1;
                     cursor_pos = n;
                     res.slot_letter = LETTER_W'(n % r + 1);
                     res.slot_vertex = VERT_W'(n / r + 1);
                  end else if (in_links[n] == 0) begin
                     hit = 1'b1;
                     cursor_pos = n;
                     res.slot_letter = LETTER_W'((1 << LETTER_W) - (n % r + 1));
                     res.slot_vertex = VERT_W'(n / r + 1);
                  end
               end
            end
         end
         default: res.status = ST_BAD;
      endcase
      res.degree_now = VERT_W'(vert_total);
      res.edge_count = EDGE_W'(edge_total);
      return res;
   endfunction

   // Watch all three channels at each edge
   always @(posedge clock) begin : watch
      rsp_beat_type want;
      if (reset) begin
         rank_reg = RANK_RESET;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            out_links[i] = '0;
            in_links[i]  = '0;
         end
         vert_total = 1;
         edge_total = 0;
         cursor_pos = 0;
         owed_q.delete();
      end else begin
         // score the response beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: response beat with no request outstanding", $time);
            end else begin
               want = owed_q.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.target_vertex !== want.target_vertex ||
                   rsp_data.slot_letter !== want.slot_letter ||
                   rsp_data.slot_vertex !== want.slot_vertex ||
                   rsp_data.degree_now !== want.degree_now ||
                   rsp_data.edge_count !== want.edge_count) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("%0t: response mismatch (expected / actual)", $time);
                     $display("  status %0d / %0d  target %0d / %0d",
                              want.status, rsp_data.status,
                              want.target_vertex, rsp_data.target_vertex);
                     $display("  slot letter %0d / %0d  slot vertex %0d / %0d",
                              want.slot_letter, rsp_data.slot_letter,
                              want.slot_vertex, rsp_data.slot_vertex);
                     $display("  degree %0d / %0d  edges %0d / %0d",
                              want.degree_now, rsp_data.degree_now,
                              want.edge_count, rsp_data.edge_count);
                  end
               end
            end
         end
         // track rank writes, then predict the request beat taken this edge
         if (csr_valid && csr_ready) rank_reg = csr_data;
         if (req_valid && !req_stall) owed_q.insert(owed_q.size(), apply_request(req_data));
      end
      error_count  <= mismatch_total;
      results_owed <= owed_q.size();
      graph_degree <= vert_total;
   end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the coset graph table engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import cgte_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
   localparam int         SETTLE_CYCLES = 80;
   localparam int         PHASE_ITEMS   = 160;
   localparam int         HOLD_CYCLES   = 400;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_beat_type      req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_beat_type      rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [RANK_W-1:0] csr_data  = RANK_RESET;

   int error_count;
   int results_owed;
   int graph_degree;
   int rank_now  = RANK_RESET;
   int rsp_taken = 0;

   coset_graph_table_engine_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   cgte_result_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .results_owed (results_owed),
      .graph_degree (graph_degree)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Count response beats to time the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) rsp_taken <= rsp_taken + 1;
   end

   // Response side pacing: free stretches, short stalls, rare long stalls, one long hold
   initial begin : rsp_pacing
      int  roll;
      bit  held_off;
      held_off = 1'b0;
      forever begin
         roll = $urandom_range(0, 99);
         if (!held_off && rsp_taken >= 300) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (roll < 40) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else if (roll < 93) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   function automatic req_beat_type req_of(input logic [1:0] kind, input int letter,
                                           input int from_v, input int to_v);
      req_beat_type beat;
      beat.req_type = kind;
      beat.letter   = LETTER_W'(letter);
      beat.src_vert = VERT_W'(from_v);
      beat.dst_vert = VERT_W'(to_v);
      return beat;
   endfunction

   // Mostly well-formed requests aimed at the current graph, some raw noise
   function automatic req_beat_type pick_request();
      req_beat_type beat;
      logic [31:0]  raw_bits;
      int           roll;
      int           top_v;
      raw_bits = $urandom;
      beat     = raw_bits[$bits(req_beat_type)-1:0];
      roll     = $urandom_range(0, 99);
      if (roll < 10) return beat;
      top_v = (graph_degree < DEGREE_CAP) ? graph_degree + 1 : DEGREE_CAP;
      beat.letter = LETTER_W'($urandom_range(1, rank_now));
      if ($urandom_range(0, 1) == 1) beat.letter = -beat.letter;
      if (roll < 55) begin
         beat.req_type = REQ_ADD;
         beat.src_vert = VERT_W'($urandom_range(1, top_v));
         beat.dst_vert = VERT_W'($urandom_range(1, top_v));
         // push the degree up now and then
         if ($urandom_range(0, 3) == 0) beat.dst_vert = VERT_W'(top_v);
      end else if (roll < 80) begin
         beat.req_type = REQ_ACT;
         beat.src_vert = VERT_W'($urandom_range(1, graph_degree));
      end else begin
         // scan ignores the other fields, leave them random
         beat.req_type = REQ_SCAN;
      end
      return beat;
   endfunction

   // Offer one request beat after a random gap and hold it until taken
   task automatic send_req(input req_beat_type beat);
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      gap  = (roll < 50) ? 0 : (roll < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait until every predicted response has arrived, then let the block settle
   task automatic drain();
      @(posedge clock);
      wait (results_owed == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rank(input logic [RANK_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      rank_now = (value == 0) ? 1 : (value > MAX_RANK) ? MAX_RANK : value;
   endtask

   initial begin : stimulus
      logic [RANK_W-1:0] rank_plan [8];
      rank_plan = '{3'd1, 3'd0, 3'd3, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset rank of two, starting from a single vertex
      send_req(req_of(REQ_SCAN, 0, 0, 0));
      send_req(req_of(REQ_ACT, 1, 1, 0));
      send_req(req_of(REQ_ADD, 1, 1, 1));
      send_req(req_of(REQ_SCAN, 5, 9, 3));
      send_req(req_of(REQ_ADD, 2, 1, 1));
      // graph is complete here, scan must come back empty
      send_req(req_of(REQ_SCAN, 0, 0, 0));
      send_req(req_of(REQ_ACT, -1, 1, 0));
      // degree grows although the slot is taken
      send_req(req_of(REQ_ADD, 1, 1, 2));
      send_req(req_of(REQ_ADD, -1, 2, 2));
      send_req(req_of(REQ_ACT, -1, 2, 0));
      send_req(req_of(REQ_ACT, 2, 2, 0));
      // bad letters and bad vertices
      send_req(req_of(REQ_ADD, 0, 1, 1));
      send_req(req_of(REQ_ADD, 3, 1, 1));
      send_req(req_of(REQ_ADD, -8, 1, 1));
      send_req(req_of(REQ_ADD, 1, 0, 1));
      send_req(req_of(REQ_ADD, 1, 1, 4));
      send_req(req_of(REQ_ADD, 2, 16, 31));
      send_req(req_of(REQ_ACT, 1, 0, 0));
      send_req(req_of(REQ_ACT, 1, 3, 0));
      send_req(req_of(REQ_ACT, 4, 16, 31));
      send_req(req_of(REQ_UNKNOWN, 7, 31, 31));
      send_req(req_of(REQ_ADD, -2, 3, 2));
      send_req(req_of(REQ_SCAN, -8, 31, 16));
      send_req(req_of(REQ_ADD, 7, 16, 16));
      req_valid <= 1'b0;

      // Random phases, one per rank setting, out-of-range ranks included
      foreach (rank_plan[p]) begin
         write_rank(rank_plan[p]);
         repeat (PHASE_ITEMS) send_req(pick_request());
         req_valid <= 1'b0;
      end

      drain();
      if (error_count == 0 && results_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
